// ===== rtl/waveset_repeat_segmenter_defines.svh =====
// assertion macros used by the checker file
`ifndef WAVESET_REPEAT_SEGMENTER_DEFINES_SVH
`define WAVESET_REPEAT_SEGMENTER_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define WRS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define WRS_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wrs_pkg.sv =====
package wrs_pkg;

  localparam int SAMPLE_W = 24;
  localparam int CHAN_W   = 3;
  localparam int FRAME_W  = 24;
  localparam int POS_W    = 25;
  localparam int REPS_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [REPS_W-1:0] REPS_RST       = 16'd1;
  localparam logic [POS_W-1:0]  DEST_FRAMES_RST = 25'h100_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPETITIONS = 2'd0,
    CFG_DEST_FRAMES = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;
    logic [FRAME_W-1:0]         frame_index;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  out_channel;
    logic               status;
    logic [FRAME_W-1:0] src_start;
    logic [FRAME_W-1:0] wave_length;
    logic [POS_W-1:0]   dest_start;
  } out_item_t;

  // per-channel state word kept in the memory
  typedef struct packed {
    logic               positive_phase;
    logic               crossing_seen;
    logic [FRAME_W-1:0] last_crossing;
    logic [POS_W-1:0]   write_position;
    logic               halted;
  } chan_state_t;

  typedef struct packed {
    logic wr_en;
    logic res_valid;
  } step_ctl_t;

endpackage

// ===== rtl/wrs_ram.sv =====
module wrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/wrs_step.sv =====
module wrs_step import wrs_pkg::*; #(
  parameter int FRAME_BITS = 24
) (
  input  in_item_t          item,
  input  chan_state_t       cur,
  input  logic [REPS_W-1:0] repetitions,
  input  logic [POS_W-1:0]  dest_frames,
  output chan_state_t       nxt,
  output step_ctl_t         ctl,
  output out_item_t         res
);

  localparam int FW = FRAME_BITS < FRAME_W ? FRAME_BITS : FRAME_W;
  localparam logic [FRAME_W-1:0] FMASK = FRAME_W'((64'd1 << FW) - 64'd1);
  // length wraps at FRAME_BITS, which may be wider than the frame field
  localparam int LEN_W  = FRAME_BITS > FRAME_W ? FRAME_BITS : FRAME_W;
  localparam logic [LEN_W-1:0] LMASK = LEN_W'((64'd1 << FRAME_BITS) - 64'd1);
  localparam int MUL_W  = LEN_W + REPS_W;
  localparam int NEED_W = MUL_W + 1;

  logic [FRAME_W-1:0] frame;
  logic               negative;
  logic               zero;
  logic [REPS_W-1:0]  reps;
  logic [LEN_W-1:0]   len;
  logic [MUL_W-1:0]   prod;
  logic [NEED_W-1:0]  need;
  logic               over;

  assign frame    = item.frame_index & FMASK;
  assign negative = item.sample[SAMPLE_W-1];
  assign zero     = (item.sample == '0);
  assign reps     = (repetitions == '0) ? REPS_RST : repetitions;
  assign len      = (LEN_W'(frame) - LEN_W'(cur.last_crossing)) & LMASK;
  assign prod     = MUL_W'(len) * MUL_W'(reps);
  assign need     = NEED_W'(prod) + NEED_W'(cur.write_position);
  assign over     = need > NEED_W'(dest_frames);

  always_comb begin
    nxt           = cur;
    ctl.wr_en     = 1'b0;
    ctl.res_valid = 1'b0;
    res.out_channel = item.channel;
    res.status      = over;
    res.src_start   = cur.last_crossing;
    res.wave_length = len[FRAME_W-1:0];
    res.dest_start  = cur.write_position;
    if (frame == '0) begin
      // channel restart; a zero sample counts as the first crossing
      nxt                = '0;
      nxt.positive_phase = !negative;
      nxt.crossing_seen  = zero;
      ctl.wr_en          = 1'b1;
    end else if (!cur.halted) begin
      if (cur.positive_phase) begin
        if (negative) begin
          nxt.positive_phase = 1'b0;
          ctl.wr_en          = 1'b1;
        end
      end else if (!negative) begin
        ctl.wr_en          = 1'b1;
        if (!cur.crossing_seen) begin
          nxt.crossing_seen  = 1'b1;
          nxt.positive_phase = 1'b1;
          nxt.last_crossing  = frame;
        end else begin
          ctl.res_valid = 1'b1;
          if (over) begin
            nxt.halted = 1'b1;
          end else begin
            nxt.write_position = need[POS_W-1:0];
            nxt.positive_phase = 1'b1;
            nxt.last_crossing  = frame;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/waveset_repeat_segmenter.sv =====
// channel   direction  payload       handshake
// in_       input      in_item_t     in_valid / in_ready
// out_      output     out_item_t    out_valid / out_ready
// cfg_      input      index, data   cfg_valid / cfg_ready (always ready)
//
// one item per cycle sustained while the output is not stalled
// an item passes the state memory read, then the update stage into the output register
// the same channel back to back is served by a bypass of the last write-back
// reset (synchronous, rst_n low) clears per-channel valid bits; state reads zero until written
// a stalled output holds the update stage, which in turn holds in_ready low
module waveset_repeat_segmenter import wrs_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int FRAME_BITS   = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
  localparam int SW = $bits(chan_state_t);

  logic [REPS_W-1:0] reps_r;
  logic [POS_W-1:0]  dest_frames_r;

  logic              s1_valid_r;
  in_item_t          s1_item_r;
  logic              s1_in_range_r;
  logic [AW-1:0]     s1_addr_r;

  logic              byp_valid_r;
  logic [AW-1:0]     byp_addr_r;
  chan_state_t       byp_data_r;

  logic [MAX_CHANNELS-1:0] ent_valid_r;

  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              in_fire;
  logic              s1_fire;
  logic              in_range;
  logic [AW-1:0]     in_addr;
  logic [SW-1:0]     ram_rdata;
  chan_state_t       cur;
  chan_state_t       nxt;
  step_ctl_t         ctl;
  out_item_t         res;
  logic              ram_we;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reps_r        <= REPS_RST;
      dest_frames_r <= DEST_FRAMES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REPETITIONS: reps_r        <= cfg_data[REPS_W-1:0];
        CFG_DEST_FRAMES: dest_frames_r <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;
  assign in_range = 32'(in_item.channel) < MAX_CHANNELS;
  assign in_addr  = AW'(in_item.channel);

  wrs_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_CHANNELS)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_addr_r),
    .wdata(nxt),
    .re   (in_fire && in_range),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  // bypass covers a write-back at the same edge as the read
  always_comb begin
    if (byp_valid_r && byp_addr_r == s1_addr_r) begin
      cur = byp_data_r;
    end else if (ent_valid_r[s1_addr_r]) begin
      cur = chan_state_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  wrs_step #(
    .FRAME_BITS(FRAME_BITS)
  ) u_step (
    .item       (s1_item_r),
    .cur        (cur),
    .repetitions(reps_r),
    .dest_frames(dest_frames_r),
    .nxt        (nxt),
    .ctl        (ctl),
    .res        (res)
  );

  assign ram_we = s1_fire && s1_in_range_r && ctl.wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      byp_valid_r <= 1'b0;
      ent_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_fire;
      end
      if (ram_we) begin
        byp_valid_r            <= 1'b1;
        ent_valid_r[s1_addr_r] <= 1'b1;
      end
      if (s1_fire) begin
        out_valid_r <= ctl.res_valid && s1_in_range_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r     <= in_item;
      s1_in_range_r <= in_range;
      s1_addr_r     <= in_addr;
    end
    if (ram_we) begin
      byp_addr_r <= s1_addr_r;
      byp_data_r <= nxt;
    end
    if (s1_fire && ctl.res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/wrs_checker.sv =====
`include "waveset_repeat_segmenter_defines.svh"

module wrs_checker import wrs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  `WRS_ASSERT_RST(a_reset_quiet, clk, !rst_n |=> !out_valid, "output valid right after reset")
  `WRS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "output item dropped")
  `WRS_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_item), "output item changed while stalled")
  // a fresh result comes from an item that was accepted on the input
  `WRS_ASSERT(a_out_cause, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without an accepted item")

endmodule

bind waveset_repeat_segmenter wrs_checker u_wrs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);
